### hdl/acc_pkg.sv
// Shared types and constants for the auto-ranging coulomb counter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package acc_pkg;

  typedef enum logic [1:0] {
    RANGE_HIGH = 2'd0,
    RANGE_MID  = 2'd1,
    RANGE_LOW  = 2'd2
  } range_e;

  typedef enum logic [2:0] {
    REG_OFF_HIGH     = 3'd0,
    REG_OFF_MID      = 3'd1,
    REG_OFF_LOW      = 3'd2,
    REG_UPPER_THR    = 3'd3,
    REG_LOWER_THR    = 3'd4,
    REG_BARREL_LIMIT = 3'd5
  } reg_idx_e;

  localparam int CNT_W    = 5;
  localparam int SUM_W    = 21;
  localparam int BARREL_W = 32;
  localparam int SUB_W    = 10;

  localparam logic [14:0]      UPPER_RST = 15'd3000;
  localparam logic [14:0]      LOWER_RST = 15'd115;
  localparam logic [19:0]      LIMIT_RST = 20'd151542;
  localparam logic [SUB_W-1:0] SUB_WRAP  = 10'd1000;

  // reciprocal constants: floor(n/5), floor(n/25), floor(n*64/539)
  localparam logic [15:0] DIV5_MUL    = 16'd52429;
  localparam int          DIV5_SHIFT  = 18;
  localparam logic [15:0] DIV25_MUL   = 16'd41944;
  localparam int          DIV25_SHIFT = 20;
  localparam logic [20:0] I10_MUL     = 21'd1992100;

  typedef struct packed {
    logic signed [9:0] off_high;
    logic signed [9:0] off_mid;
    logic signed [9:0] off_low;
    logic [14:0]       upper_thr;
    logic [14:0]       lower_thr;
    logic [19:0]       barrel_limit;
  } cfg_t;

  typedef struct packed {
    range_e             next_range;
    logic signed [15:0] scaled;
  } scale_t;

  typedef struct packed {
    range_e             next_range;
    logic signed [15:0] scaled;
    logic               done;
    logic signed [15:0] current;
  } win_t;

  typedef struct packed {
    range_e             next_range;
    logic signed [15:0] scaled;
    logic               done;
    logic signed [15:0] current;
    logic signed [12:0] current_10ma;
    logic [15:0]        charge_mah;
    logic [15:0]        charged_ah;
    logic [15:0]        discharged_ah;
  } res_t;

endpackage

`default_nettype wire

### hdl/acc_regs.sv
// APB configuration registers: range offsets, thresholds, barrel limit.
// Depends on acc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module acc_regs
  import acc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.off_high     <= '0;
      cfg_q.off_mid      <= '0;
      cfg_q.off_low      <= '0;
      cfg_q.upper_thr    <= UPPER_RST;
      cfg_q.lower_thr    <= LOWER_RST;
      cfg_q.barrel_limit <= LIMIT_RST;
    end else if (wr) begin
      unique case (idx)
        REG_OFF_HIGH:     cfg_q.off_high     <= pwdata[9:0];
        REG_OFF_MID:      cfg_q.off_mid      <= pwdata[9:0];
        REG_OFF_LOW:      cfg_q.off_low      <= pwdata[9:0];
        REG_UPPER_THR:    cfg_q.upper_thr    <= pwdata[14:0];
        REG_LOWER_THR:    cfg_q.lower_thr    <= pwdata[14:0];
        REG_BARREL_LIMIT: cfg_q.barrel_limit <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_OFF_HIGH:     prdata = {22'd0, cfg_q.off_high};
      REG_OFF_MID:      prdata = {22'd0, cfg_q.off_mid};
      REG_OFF_LOW:      prdata = {22'd0, cfg_q.off_low};
      REG_UPPER_THR:    prdata = {17'd0, cfg_q.upper_thr};
      REG_LOWER_THR:    prdata = {17'd0, cfg_q.lower_thr};
      REG_BARREL_LIMIT: prdata = {12'd0, cfg_q.barrel_limit};
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### hdl/acc_scale.sv
// Offset correction, range scaling and next-range selection (stage 1).
// Holds the range selector state. Depends on acc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module acc_scale
  import acc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              adv_i,
  input  wire logic              valid_i,
  input  wire logic signed [9:0] raw_i,
  input  wire cfg_t              cfg_i,
  output scale_t                 scale_o
);

  range_e             range_q, range_d;
  scale_t             out_q;
  logic signed [9:0]  off;
  logic signed [10:0] diff;
  logic [15:0]        prod;
  logic [16:0]        mag_x;
  logic [15:0]        mag_p;
  logic [31:0]        prod5, prod25;
  logic [15:0]        qmag;
  logic [15:0]        scaled;

  always_comb begin
    case (range_q)
      RANGE_HIGH: off = cfg_i.off_high;
      RANGE_MID:  off = cfg_i.off_mid;
      default:    off = cfg_i.off_low;
    endcase
  end

  assign diff = {raw_i[9], raw_i} - {off[9], off};

  // x64 wraps to 16 bits, x32 and x8 always fit
  always_comb begin
    case (range_q)
      RANGE_HIGH: prod = {diff[9:0], 6'd0};
      RANGE_MID:  prod = {diff[10:0], 5'd0};
      default:    prod = {{2{diff[10]}}, diff, 3'd0};
    endcase
  end

  assign mag_x  = prod[15] ? (17'd0 - {1'b1, prod}) : {1'b0, prod};
  assign mag_p  = mag_x[15:0];
  assign prod5  = 32'(mag_p) * 32'(DIV5_MUL);
  assign prod25 = 32'(mag_p) * 32'(DIV25_MUL);

  always_comb begin
    case (range_q)
      RANGE_HIGH: qmag = mag_p;
      RANGE_MID:  qmag = 16'(prod5 >> DIV5_SHIFT);
      default:    qmag = 16'(prod25 >> DIV25_SHIFT);
    endcase
  end

  assign scaled = prod[15] ? (16'd0 - qmag) : qmag;

  always_comb begin
    if (qmag > {1'b0, cfg_i.upper_thr}) begin
      range_d = RANGE_HIGH;
    end else if (qmag > {1'b0, cfg_i.lower_thr}) begin
      range_d = RANGE_MID;
    end else begin
      range_d = RANGE_LOW;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= RANGE_HIGH;
    end else if (adv_i && valid_i) begin
      range_q <= range_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      out_q.next_range <= range_d;
      out_q.scaled     <= scaled;
    end
  end

  assign scale_o = out_q;

endmodule

`default_nettype wire

### hdl/acc_window.sv
// Decimation window: sums scaled words and derives the current (stage 2).
// Depends on acc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module acc_window
  import acc_pkg::*;
#(
  parameter int WINDOW_LEN = 25
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   adv_i,
  input  wire logic   valid_i,
  input  wire scale_t scale_i,
  output win_t        win_o
);

  logic [CNT_W-1:0]        cnt_q, cnt_d, cnt_inc;
  logic signed [SUM_W-1:0] sum_q, sum_d, sum_new;
  logic signed [15:0]      cur_q, cur_d;
  logic                    done;
  win_t                    out_q;

  assign cnt_inc = cnt_q + CNT_W'(1);
  assign done    = (cnt_inc >= CNT_W'(WINDOW_LEN));
  assign sum_new = sum_q + {{(SUM_W-16){scale_i.scaled[15]}}, scale_i.scaled};

  // floor shift by 5 fits 16 bits, then negate, wrapping to 16 bits
  always_comb begin
    cnt_d = cnt_inc;
    sum_d = sum_new;
    cur_d = cur_q;
    if (done) begin
      cnt_d = '0;
      sum_d = '0;
      cur_d = 16'd0 - sum_new[20:5];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CNT_W'(1);
      sum_q <= '0;
      cur_q <= '0;
    end else if (adv_i && valid_i) begin
      cnt_q <= cnt_d;
      sum_q <= sum_d;
      cur_q <= cur_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      out_q.next_range <= scale_i.next_range;
      out_q.scaled     <= scale_i.scaled;
      out_q.done       <= done;
      out_q.current    <= cur_d;
    end
  end

  assign win_o = out_q;

endmodule

`default_nettype wire

### hdl/acc_barrel.sv
// Charge barrel, mAh and Ah counters, 10 mA current scaling (stage 3).
// Drives the result word. Depends on acc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module acc_barrel
  import acc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        adv_i,
  input  wire logic        valid_i,
  input  wire logic [19:0] barrel_limit_i,
  input  wire win_t        win_i,
  output res_t             res_o
);

  logic signed [BARREL_W-1:0] barrel_q, barrel_d, bsum;
  logic signed [BARREL_W+1:0] bsum_x, lim_x;
  logic [BARREL_W-1:0]        lim;
  logic [15:0]                mah_q, mah_d;
  logic [SUB_W-1:0]           dsub_q, dsub_d, dsub_inc;
  logic [SUB_W-1:0]           csub_q, csub_d, csub_inc;
  logic [15:0]                chg_q, chg_d, dis_q, dis_d;
  logic                       up, dn;
  logic [16:0]                cmag_x;
  logic [36:0]                i10_prod;
  logic [11:0]                i10_mag;
  logic [12:0]                i10;
  range_e                     range_q;
  logic signed [15:0]         scaled_q, cur_q;
  logic                       done_q;
  logic signed [12:0]         i10_q;

  assign lim      = {{(BARREL_W-20){1'b0}}, barrel_limit_i};
  assign bsum     = barrel_q + {{(BARREL_W-16){win_i.current[15]}}, win_i.current};
  assign bsum_x   = {{2{bsum[BARREL_W-1]}}, bsum};
  assign lim_x    = {2'b00, lim};
  assign up       = (bsum_x >= lim_x);
  assign dn       = (bsum_x <= -lim_x);
  assign dsub_inc = dsub_q + SUB_W'(1);
  assign csub_inc = csub_q + SUB_W'(1);

  always_comb begin
    barrel_d = barrel_q;
    mah_d    = mah_q;
    dsub_d   = dsub_q;
    csub_d   = csub_q;
    chg_d    = chg_q;
    dis_d    = dis_q;
    if (win_i.done) begin
      barrel_d = bsum;
      if (up) begin
        barrel_d = bsum - lim;
        mah_d    = mah_q + 16'd1;
        dsub_d   = dsub_inc;
        if (dsub_inc >= SUB_WRAP) begin
          dsub_d = '0;
          dis_d  = dis_q + 16'd1;
        end
      end else if (dn) begin
        barrel_d = bsum + lim;
        mah_d    = mah_q - 16'd1;
        csub_d   = csub_inc;
        if (csub_inc >= SUB_WRAP) begin
          csub_d = '0;
          chg_d  = chg_q + 16'd1;
        end
      end
    end
  end

  // truncating current*64/539 on the magnitude
  assign cmag_x   = win_i.current[15] ? (17'd0 - {1'b1, win_i.current})
                                      : {1'b0, win_i.current};
  assign i10_prod = 37'(cmag_x[15:0]) * 37'(I10_MUL);
  assign i10_mag  = i10_prod[35:24];
  assign i10      = win_i.current[15] ? (13'd0 - {1'b0, i10_mag}) : {1'b0, i10_mag};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      barrel_q <= '0;
      mah_q    <= '0;
      dsub_q   <= '0;
      csub_q   <= '0;
      chg_q    <= '0;
      dis_q    <= '0;
    end else if (adv_i && valid_i) begin
      barrel_q <= barrel_d;
      mah_q    <= mah_d;
      dsub_q   <= dsub_d;
      csub_q   <= csub_d;
      chg_q    <= chg_d;
      dis_q    <= dis_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      range_q  <= win_i.next_range;
      scaled_q <= win_i.scaled;
      done_q   <= win_i.done;
      cur_q    <= win_i.current;
      i10_q    <= i10;
    end
  end

  assign res_o.next_range    = range_q;
  assign res_o.scaled        = scaled_q;
  assign res_o.done          = done_q;
  assign res_o.current       = cur_q;
  assign res_o.current_10ma  = i10_q;
  assign res_o.charge_mah    = mah_q;
  assign res_o.charged_ah    = chg_q;
  assign res_o.discharged_ah = dis_q;

endmodule

`default_nettype wire

### hdl/autorange_coulomb_counter_top.sv
// Auto-ranging coulomb counter: input register, scale, window, barrel stages.
// An accepted input word passes the input register and the scale, window and barrel
// stage registers to the result word. Throughput: one word per cycle; every stage
// advances together whenever the result register is empty or being taken.
// Reset (rst_ni low, async): range high, window count 1, sums and counters 0,
// registers at their defaults. Depends on acc_pkg and all acc_* modules.
`timescale 1ns / 1ps
`default_nettype none

module autorange_coulomb_counter_top
  import acc_pkg::*;
#(
  parameter int WINDOW_LEN = 25
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // APB configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // sample stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [9:0] raw_sample
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [95:0]      m_axis_tdata,  // next_range, scaled_sample, current_value,
                                          // current_10ma, charge_mah, charged_ah,
                                          // discharged_ah
  output logic             m_axis_tlast   // window_done
);

  cfg_t              cfg;
  scale_t            scale;
  win_t              win;
  res_t              res;
  logic              adv;
  logic              v0_q, v1_q, v2_q, v3_q;
  logic signed [9:0] raw_q;

  assign adv           = ~v3_q | m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v0_q <= s_axis_tvalid;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      raw_q <= s_axis_tdata[9:0];
    end
  end

  acc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  acc_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (v0_q),
    .raw_i   (raw_q),
    .cfg_i   (cfg),
    .scale_o (scale)
  );

  acc_window #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (v1_q),
    .scale_i (scale),
    .win_o   (win)
  );

  acc_barrel u_barrel (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .valid_i        (v2_q),
    .barrel_limit_i (cfg.barrel_limit),
    .win_i          (win),
    .res_o          (res)
  );

  assign m_axis_tdata = {1'b0, res.discharged_ah, res.charged_ah, res.charge_mah,
                         res.current_10ma, res.current, res.scaled, res.next_range};
  assign m_axis_tlast = res.done;

endmodule

`default_nettype wire
